@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the rtl core
// no dependencies; each macro expands to one clocked concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_CLK(lbl, !(expr), msg)

`endif

@@ rtl/core/sha1bsh_pkg.sv @@
// types and constants for the sha-1 byte stream hasher
// no dependencies; used by sha1_byte_stream_hasher
package sha1bsh_pkg;

  // one input transfer: a message byte and its flags
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       message_end;
  } in_item_t;

  // one result transfer: a digest word and its position
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_CHAIN,
    ST_PAD,
    ST_OUT
  } state_t;

  // initial chaining words, index 0 is h0
  localparam logic [4:0][31:0] H_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  // round constants
  localparam logic [31:0] K_00_19 = 32'h5A827999;
  localparam logic [31:0] K_20_39 = 32'h6ED9EBA1;
  localparam logic [31:0] K_40_59 = 32'h8F1BBCDC;
  localparam logic [31:0] K_60_79 = 32'hCA62C1D6;

  // round boundaries
  localparam logic [6:0] SCHED_START = 7'd16;
  localparam logic [6:0] ROUND_20    = 7'd20;
  localparam logic [6:0] ROUND_40    = 7'd40;
  localparam logic [6:0] ROUND_60    = 7'd60;
  localparam logic [6:0] LAST_ROUND  = 7'd79;
  localparam logic [6:0] ROUNDS      = 7'd80;

  // padding
  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_START  = 6'd56;
  localparam logic [2:0] LAST_INDEX = 3'd4;

endpackage

@@ rtl/core/sha1_byte_stream_hasher.sv @@
// sha-1 hasher that takes a message one byte per transfer
// depends on sha1bsh_pkg and assert_macros.svh

// A byte that completes a 64-byte block starts a compression: the single round unit
// runs the 80 rounds one per cycle, then the working words are added into the chaining
// words. A transfer with message_end then pads one byte per cycle, pausing while a
// block is compressed (0x80, zeros up to offset 56, the 64-bit bit length), and so
// compresses one or two more blocks. The five digest words then leave at one per output
// transfer, h0 first, and the block returns to its initial state. No input is taken
// while a block is compressed, padded or while the digest is being sent. The block
// buffer is held in the 16-word schedule window itself, which bytes shift into and the
// rounds then roll.
`include "assert_macros.svh"

module sha1_byte_stream_hasher (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sha1bsh_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sha1bsh_pkg::out_item_t out_data
);

  sha1bsh_pkg::state_t state_r, state_nxt;

  logic [4:0][31:0]  chain_r, chain_nxt;
  logic [4:0][31:0]  work_r, work_nxt;
  logic [15:0][31:0] win_r, win_nxt;
  logic [5:0]        fill_r, fill_nxt;
  logic [60:0]       cnt_r, cnt_nxt;
  logic [6:0]        round_r, round_nxt;
  logic [2:0]        wi_r, wi_nxt;
  logic              end_r, end_nxt;
  logic              pad_first_r, pad_first_nxt;
  logic              len_phase_r, len_phase_nxt;

  logic              in_xfer;
  logic              out_xfer;
  logic              push_en;
  logic [7:0]        push_byte;
  logic [5:0]        fill_inc;
  logic              push_wrap;
  logic              len_active;
  logic [7:0][7:0]   len_bytes;
  logic [31:0]       w_exp;
  logic [31:0]       w_cur;
  logic [31:0]       f_val;
  logic [31:0]       k_val;
  logic [31:0]       temp;

  // handshake transfers
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  // byte push into the window
  assign fill_inc   = fill_r + 6'd1;
  assign push_wrap  = (fill_inc == 6'd0);
  assign len_bytes  = {cnt_r, 3'b000};
  assign len_active = len_phase_r || (!pad_first_r && (fill_r == sha1bsh_pkg::LEN_START));

  always_comb begin
    push_en   = 1'b0;
    push_byte = 8'h00;
    if (state_r == sha1bsh_pkg::ST_IDLE) begin
      push_en   = in_xfer && in_data.byte_present;
      push_byte = in_data.data_byte;
    end else if (state_r == sha1bsh_pkg::ST_PAD) begin
      push_en = 1'b1;
      if (pad_first_r) begin
        push_byte = sha1bsh_pkg::PAD_BYTE;
      end else if (len_active) begin
        push_byte = len_bytes[3'd7 - fill_r[2:0]];
      end
    end
  end

  // round unit: schedule word, round function and sum
  assign w_exp = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
  assign w_cur = (round_r < sha1bsh_pkg::SCHED_START) ? win_r[0] : {w_exp[30:0], w_exp[31]};

  always_comb begin
    if (round_r < sha1bsh_pkg::ROUND_20) begin
      f_val = (work_r[1] & work_r[2]) | (~work_r[1] & work_r[3]);
      k_val = sha1bsh_pkg::K_00_19;
    end else if (round_r < sha1bsh_pkg::ROUND_40) begin
      f_val = work_r[1] ^ work_r[2] ^ work_r[3];
      k_val = sha1bsh_pkg::K_20_39;
    end else if (round_r < sha1bsh_pkg::ROUND_60) begin
      f_val = (work_r[1] & work_r[2]) | (work_r[1] & work_r[3]) | (work_r[2] & work_r[3]);
      k_val = sha1bsh_pkg::K_40_59;
    end else begin
      f_val = work_r[1] ^ work_r[2] ^ work_r[3];
      k_val = sha1bsh_pkg::K_60_79;
    end
  end

  assign temp = {work_r[0][26:0], work_r[0][31:27]} + f_val + work_r[4] + k_val + w_cur;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sha1bsh_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (in_data.byte_present && push_wrap) begin
            state_nxt = sha1bsh_pkg::ST_ROUND;
          end else if (in_data.message_end) begin
            state_nxt = sha1bsh_pkg::ST_PAD;
          end
        end
      end
      sha1bsh_pkg::ST_ROUND: begin
        if (round_r == sha1bsh_pkg::LAST_ROUND) begin
          state_nxt = sha1bsh_pkg::ST_CHAIN;
        end
      end
      sha1bsh_pkg::ST_CHAIN: begin
        if (!end_r) begin
          state_nxt = sha1bsh_pkg::ST_IDLE;
        end else if (len_phase_r) begin
          state_nxt = sha1bsh_pkg::ST_OUT;
        end else begin
          state_nxt = sha1bsh_pkg::ST_PAD;
        end
      end
      sha1bsh_pkg::ST_PAD: begin
        if (push_wrap) begin
          state_nxt = sha1bsh_pkg::ST_ROUND;
        end
      end
      sha1bsh_pkg::ST_OUT: begin
        if (out_xfer && (wi_r == sha1bsh_pkg::LAST_INDEX)) begin
          state_nxt = sha1bsh_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sha1bsh_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall              = (state_r != sha1bsh_pkg::ST_IDLE);
    out_valid             = (state_r == sha1bsh_pkg::ST_OUT);
    out_data.digest_word  = chain_r[wi_r];
    out_data.word_index   = wi_r;
    out_data.last_word    = (wi_r == sha1bsh_pkg::LAST_INDEX);
  end

  // datapath and counters
  always_comb begin
    chain_nxt     = chain_r;
    work_nxt      = work_r;
    win_nxt       = win_r;
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    round_nxt     = round_r;
    wi_nxt        = wi_r;
    end_nxt       = end_r;
    pad_first_nxt = pad_first_r;
    len_phase_nxt = len_phase_r;

    // message flags on an input transfer
    if ((state_r == sha1bsh_pkg::ST_IDLE) && in_xfer) begin
      if (in_data.byte_present) begin
        cnt_nxt = cnt_r + 61'd1;
      end
      if (in_data.message_end) begin
        end_nxt       = 1'b1;
        pad_first_nxt = 1'b1;
      end
    end

    // padding flags
    if (state_r == sha1bsh_pkg::ST_PAD) begin
      pad_first_nxt = 1'b0;
      len_phase_nxt = len_active;
    end

    // shift a byte in, start a compression on a full block
    if (push_en) begin
      for (int i = 0; i < 15; i++) begin
        win_nxt[i] = {win_r[i][23:0], win_r[i+1][31:24]};
      end
      win_nxt[15] = {win_r[15][23:0], push_byte};
      fill_nxt    = fill_inc;
      if (push_wrap) begin
        work_nxt  = chain_r;
        round_nxt = 7'd0;
      end
    end

    // one round per cycle, window rolls by one word
    if (state_r == sha1bsh_pkg::ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        win_nxt[i] = win_r[i+1];
      end
      win_nxt[15] = w_cur;
      work_nxt[0] = temp;
      work_nxt[1] = work_r[0];
      work_nxt[2] = {work_r[1][1:0], work_r[1][31:2]};
      work_nxt[3] = work_r[2];
      work_nxt[4] = work_r[3];
      round_nxt   = (round_r == sha1bsh_pkg::LAST_ROUND) ? 7'd0 : round_r + 7'd1;
    end

    // fold working words into the chain
    if (state_r == sha1bsh_pkg::ST_CHAIN) begin
      for (int i = 0; i < 5; i++) begin
        chain_nxt[i] = chain_r[i] + work_r[i];
      end
    end

    // digest output, back to initial state after the last word
    if ((state_r == sha1bsh_pkg::ST_OUT) && out_xfer) begin
      if (wi_r == sha1bsh_pkg::LAST_INDEX) begin
        chain_nxt     = sha1bsh_pkg::H_INIT;
        cnt_nxt       = 61'd0;
        fill_nxt      = 6'd0;
        wi_nxt        = 3'd0;
        end_nxt       = 1'b0;
        pad_first_nxt = 1'b0;
        len_phase_nxt = 1'b0;
      end else begin
        wi_nxt = wi_r + 3'd1;
      end
    end
  end

  // control and chaining registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha1bsh_pkg::ST_IDLE;
      chain_r     <= sha1bsh_pkg::H_INIT;
      fill_r      <= 6'd0;
      cnt_r       <= 61'd0;
      round_r     <= 7'd0;
      wi_r        <= 3'd0;
      end_r       <= 1'b0;
      pad_first_r <= 1'b0;
      len_phase_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chain_r     <= chain_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      round_r     <= round_nxt;
      wi_r        <= wi_nxt;
      end_r       <= end_nxt;
      pad_first_r <= pad_first_nxt;
      len_phase_r <= len_phase_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    win_r  <= win_nxt;
  end

  // checks
  `ASSERT_CLK(a_round_range, (state_r == sha1bsh_pkg::ST_ROUND) |-> (round_r < sha1bsh_pkg::ROUNDS), "round index out of range")
  `ASSERT_CLK(a_out_block_empty, (state_r == sha1bsh_pkg::ST_OUT) |-> (fill_r == 6'd0), "digest sent with a partial block")
  `ASSERT_CLK(a_last_resets, (out_xfer && out_data.last_word) |=> ((state_r == sha1bsh_pkg::ST_IDLE) && (cnt_r == 61'd0)), "state not cleared after digest")
  `ASSERT_NEVER(a_len_without_end, len_phase_r && !end_r, "length padding outside a message end")

endmodule

@@ tb/tb_top.sv @@
// testbench for sha1_byte_stream_hasher: byte transfers in, digest word transfers out
// depends on sha1bsh_pkg for the transfer types; a sha-1 model inside the bench
// predicts every digest word and the checker compares each field in order

module tb_top;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 300;
  localparam int HOLD_CYCLES   = 500;
  localparam int PHASE_ITEMS   = 30;

  // sha-1 round constants and padding values for the model
  localparam logic [31:0] RC_00_19   = 32'h5A827999;
  localparam logic [31:0] RC_20_39   = 32'h6ED9EBA1;
  localparam logic [31:0] RC_40_59   = 32'h8F1BBCDC;
  localparam logic [31:0] RC_60_79   = 32'hCA62C1D6;
  localparam logic [7:0]  PAD_MARK   = 8'h80;
  localparam int          LEN_OFFSET = 56;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  sha1bsh_pkg::in_item_t  in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  sha1bsh_pkg::out_item_t out_data;

  // model state: chaining words, block buffer, fill and message length
  logic [31:0] chain_h [0:4];
  logic [7:0]  block_bytes [0:63];
  int unsigned block_fill;
  logic [60:0] msg_bytes;

  sha1bsh_pkg::out_item_t expected_digest_words [$];

  int errors = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int send_gap_pct = 25;
  int recv_gap_pct = 62;
  int hold_left = 0;

  sha1_byte_stream_hasher DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- sha-1 model

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic void restart_hash();
    chain_h[0] = 32'h67452301;
    chain_h[1] = 32'hEFCDAB89;
    chain_h[2] = 32'h98BADCFE;
    chain_h[3] = 32'h10325476;
    chain_h[4] = 32'hC3D2E1F0;
    block_fill = 0;
    msg_bytes  = '0;
  endfunction

  // 80 rounds over the buffered block, folded into the chaining words
  function automatic void compress_block();
    logic [31:0] w [0:15];
    logic [31:0] a, b, c, d, e, f, k, t;
    int r;
    for (r = 0; r < 16; r++) begin
      w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2], block_bytes[4*r+3]};
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (r = 0; r < 80; r++) begin
      if (r >= 16) begin
        w[r % 16] = rotl(w[(r - 3) % 16] ^ w[(r - 8) % 16] ^ w[(r - 14) % 16] ^ w[r % 16], 1);
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = RC_00_19;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = RC_20_39;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RC_40_59;
      end else begin
        f = b ^ c ^ d;
        k = RC_60_79;
      end
      t = rotl(a, 5) + f + e + k + w[r % 16];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] = chain_h[0] + a;
    chain_h[1] = chain_h[1] + b;
    chain_h[2] = chain_h[2] + c;
    chain_h[3] = chain_h[3] + d;
    chain_h[4] = chain_h[4] + e;
  endfunction

  function automatic void absorb_byte(input logic [7:0] v);
    block_bytes[block_fill] = v;
    block_fill = (block_fill + 1) % 64;
    if (block_fill == 0) begin
      compress_block();
    end
  endfunction

  // one accepted input transfer; a message end queues the five digest words
  function automatic void sha1_absorb_transfer(input sha1bsh_pkg::in_item_t item);
    logic [63:0]            bit_len;
    sha1bsh_pkg::out_item_t word;
    int                     i;
    if (item.byte_present) begin
      msg_bytes = msg_bytes + 1'b1;
      absorb_byte(item.data_byte);
    end
    if (item.message_end) begin
      bit_len = {msg_bytes, 3'b000};
      absorb_byte(PAD_MARK);
      while (block_fill != LEN_OFFSET) begin
        absorb_byte(8'h00);
      end
      for (i = 7; i >= 0; i--) begin
        absorb_byte(bit_len[8*i +: 8]);
      end
      for (i = 0; i < 5; i++) begin
        word.digest_word = chain_h[i];
        word.word_index  = 3'(i);
        word.last_word   = (i == 4);
        expected_digest_words = {expected_digest_words, word};
      end
      restart_hash();
    end
  endfunction

  // ---------------------------------------------------------------- driving

  // offer one transfer after random gaps and hold it until accepted
  task automatic send_item(input logic [7:0] data, input logic present, input logic last);
    sha1bsh_pkg::in_item_t item;
    item.data_byte    = data;
    item.byte_present = present;
    item.message_end  = last;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    sha1_absorb_transfer(item);
    if (present || last) begin
      items_sent++;
    end
  endtask

  // random bytes with occasional no-byte transfers; ends on the last byte or on an
  // empty final transfer
  task automatic send_message(input int len, input bit end_on_byte, input bit with_noise);
    int n;
    for (n = 0; n < len; n++) begin
      if (with_noise && $urandom_range(0, 15) == 0) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      send_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (n == len - 1));
    end
    if (!(end_on_byte && len > 0)) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  // drop valid and wait until every predicted digest word has come out
  task automatic wait_for_digests();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_digest_words.size() != 0);
  endtask

  // receiver stall: a counted hold-off when requested, random otherwise
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_gap_pct);
    end
  end

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin : check_digest
    sha1bsh_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_digest_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected digest transfer, expected none actual %h", $time, out_data);
      end else begin
        want = expected_digest_words.pop_front();
        if (out_data.digest_word !== want.digest_word) begin
          errors++;
          $display("%0t: digest_word expected %h actual %h", $time,
                   want.digest_word, out_data.digest_word);
        end
        if (out_data.word_index !== want.word_index) begin
          errors++;
          $display("%0t: word_index expected %0d actual %0d", $time,
                   want.word_index, out_data.word_index);
        end
        if (out_data.last_word !== want.last_word) begin
          errors++;
          $display("%0t: last_word expected %b actual %b", $time,
                   want.last_word, out_data.last_word);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  // empty message on a fresh state, twice in a row
  task automatic test_empty_message();
    send_item(8'h5A, 1'b0, 1'b1);
    send_item(8'hA5, 1'b0, 1'b1);
  endtask

  // transfers with neither byte nor end, mixed into a short message, must leave the hash untouched
  task automatic test_idle_transfer();
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h7E, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
  endtask

  // known short messages and byte extremes, both ways of ending
  task automatic test_short_messages();
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
  endtask

  // random messages, mostly short, some on the padding and block boundaries
  task automatic test_random_messages(input int item_budget);
    int start_count;
    int pick;
    int len;
    start_count = items_sent;
    while (items_sent - start_count < item_budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        len = $urandom_range(0, 12);
      end else if (pick < 88) begin
        case ($urandom_range(0, 7))
          0: len = 55;
          1: len = 56;
          2: len = 57;
          3: len = 63;
          4: len = 64;
          5: len = 65;
          6: len = 119;
          default: len = 120;
        endcase
      end else begin
        len = $urandom_range(13, 100);
      end
      send_message(len, 1'($urandom_range(0, 1)), 1'b1);
    end
  endtask

  // receiver holds off while a long message and the next one are offered, so the
  // digest backs up and the input stalls
  task automatic test_output_backpressure();
    wait_for_digests();
    @(negedge clk);
    hold_left = HOLD_CYCLES;
    @(posedge clk);
    send_message(70, 1'b1, 1'b0);
    send_message(20, 1'b0, 1'b0);
  endtask

  // sender pauses until the digest is out before the next message starts
  task automatic test_pause_between_messages();
    send_message(9, 1'b1, 1'b0);
    wait_for_digests();
    send_message(64, 1'b0, 1'b0);
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    restart_hash();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_message();
    test_idle_transfer();
    test_short_messages();
    test_random_messages(PHASE_ITEMS);

    wait_for_digests();
    send_gap_pct = 62;
    recv_gap_pct = 25;
    test_random_messages(PHASE_ITEMS);

    wait_for_digests();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_random_messages(PHASE_ITEMS);
    test_output_backpressure();
    test_pause_between_messages();

    wait_for_digests();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sha1_byte_stream_hasher.f @@
+incdir+rtl/core
rtl/core/sha1bsh_pkg.sv
rtl/core/sha1_byte_stream_hasher.sv
tb/tb_top.sv
